// File: design/ds2rfc_pkg.sv
package ds2rfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_BYTE_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CHECKSUM = 2'd2;

    // Frame status codes
    localparam logic [STAT_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] ST_GOOD = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADLEN = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADSUM = 2'd3;

    localparam logic [BYTE_W-1:0] HDR_LEN_SHORT = 8'd2;
    localparam logic [BYTE_W-1:0] HDR_LEN_LONG = 8'd3;

    typedef struct packed {
        logic              three_byte_header;
        logic [BYTE_W-1:0] max_frame_length;
        logic              skip_checksum;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_position;
        logic              frame_end;
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

endpackage

// File: design/ds2rfc_cfg.sv
module ds2rfc_cfg
    import ds2rfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three_byte_header <= 1'b1;
            r_cfg.max_frame_length  <= 8'hFF;
            r_cfg.skip_checksum     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THREE_BYTE_HEADER: r_cfg.three_byte_header <= i_cfg_wdata[0];
                CFG_MAX_FRAME_LENGTH:  r_cfg.max_frame_length  <= i_cfg_wdata;
                CFG_SKIP_CHECKSUM:     r_cfg.skip_checksum     <= i_cfg_wdata[0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/ds2rfc_eval.sv
module ds2rfc_eval
    import ds2rfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    logic [BYTE_W-1:0] r_pos;
    logic [BYTE_W-1:0] r_cap;
    logic [BYTE_W-1:0] r_xor;

    logic [BYTE_W-1:0] w_hdr;
    logic              w_at_len;
    logic              w_past_len;
    logic [STAT_W-1:0] w_sum_st;
    logic              w_end;
    logic [STAT_W-1:0] w_st;
    logic [BYTE_W-1:0] w_flen;

    always_comb begin
        w_hdr      = i_cfg.three_byte_header ? HDR_LEN_LONG : HDR_LEN_SHORT;
        w_at_len   = (r_pos == (w_hdr - 8'd1));
        w_past_len = (r_pos >= w_hdr);
        w_sum_st   = (i_cfg.skip_checksum || (i_byte == r_xor)) ? ST_GOOD : ST_BADSUM;
        w_end      = 1'b0;
        w_st       = ST_BUSY;
        w_flen     = '0;
        if (w_at_len) begin
            w_flen = i_byte;
            if ((i_byte < w_hdr) || (i_byte > i_cfg.max_frame_length)) begin
                w_end = 1'b1;
                w_st  = ST_BADLEN;
            end else if (i_byte == w_hdr) begin
                // header-only telegram: length byte doubles as checksum
                w_end = 1'b1;
                w_st  = w_sum_st;
            end
        end else if (w_past_len) begin
            w_flen = r_cap;
            if (({1'b0, r_pos} + 9'd1) >= {1'b0, r_cap}) begin
                w_end = 1'b1;
                w_st  = w_sum_st;
            end
        end
        o_res.data_byte     = i_byte;
        o_res.byte_position = r_pos;
        o_res.frame_end     = w_end;
        o_res.status        = w_st;
        o_res.frame_length  = w_end ? w_flen : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cap <= '0;
            r_xor <= '0;
        end else if (i_step) begin
            if (w_end) begin
                r_pos <= '0;
                r_cap <= '0;
                r_xor <= '0;
            end else begin
                r_pos <= r_pos + 8'd1;
                r_xor <= r_xor ^ i_byte;
                if (w_at_len) begin
                    r_cap <= i_byte;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_end) |=> (r_pos == '0 && r_xor == '0 && r_cap == '0))
        else $error("frame state not cleared after frame end");
    a_advance_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !w_end) |=> (r_pos == $past(r_pos) + 8'd1))
        else $error("position did not advance within frame");
    a_end_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.frame_end == (o_res.status != ST_BUSY)))
        else $error("frame end and status disagree");
`endif

endmodule

// File: design/ds2_response_frame_checker_top.sv
// Response telegram checker, receive side. One received byte per request on the
// rx channel gives exactly one result request carrying the byte, its position in
// the telegram, an end flag, the status and (at the end) the telegram length.
// Throughput is one byte per clock while the result side does not stall. Each byte
// passes the input register, then the result register; a stalled result holds the
// input register and stalls rx. The rate is set by the frame state (position,
// captured length, running XOR), which updates once per byte. Configuration writes
// take effect on the next edge and apply from the next byte evaluated; write only
// while no byte is in flight.
module ds2_response_frame_checker_top
    import ds2rfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic [BYTE_W-1:0]    o_byte_position,
    output logic                 o_frame_end,
    output logic [STAT_W-1:0]    o_status,
    output logic [BYTE_W-1:0]    o_frame_length
);

    t_cfg              w_cfg;
    t_result           w_res;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_step;

    ds2rfc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ds2rfc_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // held byte moves on when the result register is empty or being drained
    assign w_step     = r_in_valid && (!r_out_valid || !i_res_stall);
    assign o_rx_stall = r_in_valid && !w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_rx_stall) begin
                r_in_valid <= i_rx_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_data_byte     = r_out.data_byte;
    assign o_byte_position = r_out.byte_position;
    assign o_frame_end     = r_out.frame_end;
    assign o_status        = r_out.status;
    assign o_frame_length  = r_out.frame_length;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (r_in_valid && r_out_valid && i_res_stall))
        else $error("rx stalled without a blocked result");
    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_res_valid)
        else $error("result register not loaded after step");
    a_idle_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_frame_end) |-> (o_frame_length == '0 && o_status == ST_BUSY))
        else $error("in-progress result carries end data");
`endif

endmodule

// File: tb/ds2_response_frame_checker_top_tb.sv
`timescale 1ns / 1ps

module ds2_response_frame_checker_top_tb;
    import ds2rfc_pkg::*;

    localparam int N_ITEMS = 1500;
    localparam int N_PHASES = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // index 3 is not mapped to any register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_RX, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    val;
        logic                 chk;
        t_result              res;
    } t_dir_row;

    bit                   i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_wdata;
    logic                 i_rx_valid;
    logic                 o_rx_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_res_valid;
    logic                 i_res_stall;
    logic [BYTE_W-1:0]    o_data_byte;
    logic [BYTE_W-1:0]    o_byte_position;
    logic                 o_frame_end;
    logic [STAT_W-1:0]    o_status;
    logic [BYTE_W-1:0]    o_frame_length;

    // typed expectation riding along with the current rx request
    logic    pin_use;
    t_result pin_exp;

    // predictor copy of registers and telegram state
    logic              m_hdr3;
    logic [BYTE_W-1:0] m_max;
    logic              m_skip;
    logic [BYTE_W-1:0] rx_pos;
    logic [BYTE_W-1:0] rx_len;
    logic [BYTE_W-1:0] rx_xor;

    t_result  pending_results[$];
    t_dir_row rows[$];
    int       n_errors;
    int       n_sent;
    int       idle_cycles;
    bit       calm;

    ds2_response_frame_checker_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_position (o_byte_position),
        .o_frame_end     (o_frame_end),
        .o_status        (o_status),
        .o_frame_length  (o_frame_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [STAT_W-1:0] trailer_status(input logic [BYTE_W-1:0] b);
        if (m_skip)
            return ST_GOOD;
        return (b == rx_xor) ? ST_GOOD : ST_BADSUM;
    endfunction

    function automatic t_result predict_frame_byte(input logic [BYTE_W-1:0] b);
        t_result           r;
        logic [BYTE_W-1:0] hdr;
        logic              fin;
        logic [STAT_W-1:0] st;
        logic [BYTE_W-1:0] flen;
        hdr = m_hdr3 ? HDR_LEN_LONG : HDR_LEN_SHORT;
        fin = 1'b0;
        st = ST_BUSY;
        flen = '0;
        if (rx_pos == hdr - 8'd1) begin
            rx_len = b;
            if (b < hdr || b > m_max) begin
                fin = 1'b1;
                st = ST_BADLEN;
            end else if (b == hdr) begin
                // header-only telegram: length byte doubles as checksum
                fin = 1'b1;
                st = trailer_status(b);
            end
            flen = b;
        end else if (rx_pos >= hdr) begin
            if ({1'b0, rx_pos} + 9'd1 >= {1'b0, rx_len}) begin
                fin = 1'b1;
                st = trailer_status(b);
            end
            flen = rx_len;
        end
        r.data_byte = b;
        r.byte_position = rx_pos;
        r.frame_end = fin;
        r.status = st;
        r.frame_length = fin ? flen : 8'd0;
        if (fin) begin
            rx_pos = '0;
            rx_len = '0;
            rx_xor = '0;
        end else begin
            rx_xor = rx_xor ^ b;
            rx_pos = rx_pos + 8'd1;
        end
        return r;
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endfunction

    // result checking, then prediction of the request taken on this edge
    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                got = '{o_data_byte, o_byte_position, o_frame_end, o_status, o_frame_length};
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: unexpected result, expected none, actual byte 0x%0h pos %0d",
                             $time, got.data_byte, got.byte_position);
                end else begin
                    want = pending_results.pop_front();
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("byte_position", want.byte_position, got.byte_position);
                    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("frame_length", want.frame_length, got.frame_length);
                end
            end
            if (i_rx_valid && !o_rx_stall) begin
                want = predict_frame_byte(i_rx_byte);
                if (pin_use)
                    want = pin_exp;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        i_res_stall <= (i_rst_n && !calm) ? ($urandom_range(99) < 25) : 1'b0;
    end

    function automatic void add_rx(input logic [BYTE_W-1:0] b, input logic chk,
                                   input t_result res);
        rows.push_back('{ROW_RX, CFG_UNUSED, b, chk, res});
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BYTE_W-1:0] val);
        rows.push_back('{ROW_REG, idx, val, 1'b0, t_result'('0)});
    endfunction

    task automatic send_rx(input logic [BYTE_W-1:0] b, input logic chk, input t_result res);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 25) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        pin_use <= chk;
        pin_exp <= res;
        do
            @(posedge i_clk);
        while (!(i_rx_valid && !o_rx_stall));
        n_sent++;
    endtask

    // registers only change once every byte in flight has come out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_THREE_BYTE_HEADER: m_hdr3 = val[0];
            CFG_MAX_FRAME_LENGTH:  m_max = val;
            CFG_SKIP_CHECKSUM:     m_skip = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_telegram();
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] b;
        int                len;
        int                n;
        int                kind;
        int                hi;
        int                mx;
        hdr = m_hdr3 ? HDR_LEN_LONG : HDR_LEN_SHORT;
        mx = m_max;
        kind = $urandom_range(99);
        if (kind >= 92) begin
            // line noise, usually leaves the telegram half done
            repeat ($urandom_range(6, 1)) send_rx(BYTE_W'($urandom_range(255)), 1'b0, '0);
            return;
        end
        if (kind >= 80) begin
            if (mx < 255 && $urandom_range(1))
                len = $urandom_range(255, mx + 1);
            else
                len = $urandom_range(hdr - 1, 0);
            n = hdr;
        end else if (mx < hdr) begin
            len = hdr;
            n = hdr;
        end else begin
            hi = (mx < 20) ? mx : 20;
            if ($urandom_range(199) < 3)
                hi = mx;
            len = $urandom_range(hi, hdr);
            if ($urandom_range(199) < 2)
                len = mx;
            n = len;
        end
        x = '0;
        for (int k = 0; k < n; k++) begin
            if (k == hdr - 1)
                b = BYTE_W'(len);
            else if (k == len - 1)
                b = (kind >= 65) ? x ^ BYTE_W'($urandom_range(255, 1)) : x;
            else
                b = BYTE_W'($urandom_range(255));
            x = x ^ b;
            send_rx(b, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_rx_valid = 1'b0;
        i_rx_byte = '0;
        i_res_stall = 1'b0;
        pin_use = 1'b0;
        pin_exp = '0;
        m_hdr3 = 1'b1;
        m_max = 8'd255;
        m_skip = 1'b0;
        rx_pos = '0;
        rx_len = '0;
        rx_xor = '0;
        n_errors = 0;
        n_sent = 0;
        idle_cycles = 0;
        calm = 1'b0;

        // good 5-byte telegram from reset defaults
        add_rx(8'h00, 1'b1, '{8'h00, 8'd0, 1'b0, ST_BUSY, 8'd0});
        add_rx(8'hFF, 1'b0, '0);
        add_rx(8'h05, 1'b0, '0);
        add_rx(8'hA5, 1'b0, '0);
        add_rx(8'h5F, 1'b1, '{8'h5F, 8'd4, 1'b1, ST_GOOD, 8'd5});
        // header-only telegrams, good and bad checksum
        add_rx(8'h01, 1'b0, '0);
        add_rx(8'h02, 1'b0, '0);
        add_rx(8'h03, 1'b1, '{8'h03, 8'd2, 1'b1, ST_GOOD, 8'd3});
        add_rx(8'hFF, 1'b0, '0);
        add_rx(8'h00, 1'b0, '0);
        add_rx(8'h03, 1'b1, '{8'h03, 8'd2, 1'b1, ST_BADSUM, 8'd3});
        // length below header size
        add_rx(8'h00, 1'b0, '0);
        add_rx(8'h00, 1'b0, '0);
        add_rx(8'h02, 1'b1, '{8'h02, 8'd2, 1'b1, ST_BADLEN, 8'd2});
        // length above limit
        add_reg(CFG_MAX_FRAME_LENGTH, 8'd8);
        add_rx(8'h00, 1'b0, '0);
        add_rx(8'h00, 1'b0, '0);
        add_rx(8'hFF, 1'b1, '{8'hFF, 8'd2, 1'b1, ST_BADLEN, 8'hFF});
        // two-byte header
        add_reg(CFG_THREE_BYTE_HEADER, 8'd0);
        add_rx(8'h55, 1'b0, '0);
        add_rx(8'h02, 1'b1, '{8'h02, 8'd1, 1'b1, ST_BADSUM, 8'd2});
        // checksum disabled
        add_reg(CFG_SKIP_CHECKSUM, 8'd1);
        add_rx(8'h10, 1'b0, '0);
        add_rx(8'h03, 1'b0, '0);
        add_rx(8'h99, 1'b1, '{8'h99, 8'd2, 1'b1, ST_GOOD, 8'd3});
        // header shrinks mid-telegram, past the length byte with none captured
        add_reg(CFG_SKIP_CHECKSUM, 8'd0);
        add_reg(CFG_THREE_BYTE_HEADER, 8'd1);
        add_reg(CFG_UNUSED, 8'hFE);
        add_rx(8'h11, 1'b0, '0);
        add_rx(8'h22, 1'b0, '0);
        add_reg(CFG_THREE_BYTE_HEADER, 8'd0);
        add_rx(8'h33, 1'b1, '{8'h33, 8'd2, 1'b1, ST_GOOD, 8'd0});
        // zero limit rejects everything
        add_reg(CFG_MAX_FRAME_LENGTH, 8'd0);
        add_rx(8'h7E, 1'b0, '0);
        add_rx(8'h02, 1'b1, '{8'h02, 8'd1, 1'b1, ST_BADLEN, 8'd2});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_rx(rows[i].val, rows[i].chk, rows[i].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_THREE_BYTE_HEADER, 8'd1);
                    write_reg(CFG_MAX_FRAME_LENGTH, 8'd255);
                    write_reg(CFG_SKIP_CHECKSUM, 8'd0);
                end
                1: begin
                    write_reg(CFG_THREE_BYTE_HEADER, 8'd0);
                    write_reg(CFG_SKIP_CHECKSUM, 8'd1);
                end
                2: begin
                    write_reg(CFG_THREE_BYTE_HEADER, 8'd1);
                    write_reg(CFG_MAX_FRAME_LENGTH, BYTE_W'($urandom_range(40, 3)));
                    write_reg(CFG_SKIP_CHECKSUM, 8'd0);
                end
                3: begin
                    write_reg(CFG_THREE_BYTE_HEADER, 8'd0);
                    write_reg(CFG_MAX_FRAME_LENGTH, 8'd2);
                end
                4: begin
                    write_reg(CFG_THREE_BYTE_HEADER, BYTE_W'($urandom_range(1)));
                    write_reg(CFG_MAX_FRAME_LENGTH, BYTE_W'($urandom_range(255)));
                    write_reg(CFG_SKIP_CHECKSUM, BYTE_W'($urandom_range(1)));
                    write_reg(CFG_UNUSED, BYTE_W'($urandom_range(255)));
                end
                default: begin
                    write_reg(CFG_THREE_BYTE_HEADER, 8'd1);
                    write_reg(CFG_MAX_FRAME_LENGTH, 8'd3);
                    write_reg(CFG_SKIP_CHECKSUM, BYTE_W'($urandom_range(1)));
                end
            endcase
            @(posedge i_clk);
            calm = (ph == 2);
            phase_start = n_sent;
            while (n_sent - phase_start < N_ITEMS / N_PHASES)
                send_telegram();
        end

        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
design/ds2rfc_pkg.sv
design/ds2rfc_cfg.sv
design/ds2rfc_eval.sv
design/ds2_response_frame_checker_top.sv
tb/ds2_response_frame_checker_top_tb.sv
